### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks sampled on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ASSERT_AT(lbl, en, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (en) |-> (cond)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(lbl, en, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (en) |=> (cond)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, en, cond)
`define ASSERT_NEXT(lbl, en, cond)
`endif
`endif

### hdl/iis_pkg.sv
// ---------------------------------------------------------------------------
// Integral image package
// Field widths, register indexes and shared helpers.
// ---------------------------------------------------------------------------
package iis_pkg;

  localparam int SUM_W       = 28;
  localparam int PIXEL_W     = 8;
  localparam int DIM_W       = 11;
  localparam int DIM_CLAMP_W = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

  // Per-pixel position flags handed from the scan front to the adder stage
  typedef struct packed {
    logic first_row;
    logic frame_end;
  } scan_flags_t;

  // Last valid position for a dimension: zero counts as one, large values saturate
  function automatic logic [DIM_CLAMP_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                      input int maxv);
    logic [DIM_CLAMP_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > maxv) begin
      r = DIM_CLAMP_W'(maxv - 1);
    end else begin
      r = DIM_CLAMP_W'(v) - DIM_CLAMP_W'(1);
    end
    return r;
  endfunction

endpackage

### hdl/iis_line_store.sv
// ---------------------------------------------------------------------------
// Integral image line store
// One-row memory of summed-area values, one write and one registered read.
// ---------------------------------------------------------------------------
module iis_line_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 28
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write the finished sum of the column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the entry above; hold the data while the reader stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/iis_scan.sv
// ---------------------------------------------------------------------------
// Integral image scan front
// Frame size registers, raster position counters and the running row sum.
// ---------------------------------------------------------------------------
module iis_scan
  import iis_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COL_W      = 10,
  parameter int ROW_IDX_W  = 10,
  parameter int USE_BITS   = 8,
  parameter int ROW_W      = 18
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 advance,
  input  logic [PIXEL_W-1:0]   pixel,
  output logic [COL_W-1:0]     col,
  output logic [ROW_W-1:0]     row_sum_new,
  output scan_flags_t          flags
);

  logic [COL_W-1:0]     w_last;
  logic [ROW_IDX_W-1:0] h_last;
  logic [ROW_IDX_W-1:0] row;
  logic [ROW_W-1:0]     row_sum;
  logic                 row_end;

  // Add the masked pixel into the row sum
  assign row_sum_new = row_sum + ROW_W'(pixel[USE_BITS-1:0]);
  assign row_end     = (col == w_last);
  assign flags.first_row = (row == '0);
  assign flags.frame_end = row_end && (row == h_last);

  // Advance the raster position; a width or height register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      w_last  <= COL_W'(dim_last(DIM_RESET, MAX_WIDTH));
      h_last  <= ROW_IDX_W'(dim_last(DIM_RESET, MAX_HEIGHT));
      col     <= '0;
      row     <= '0;
      row_sum <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          w_last  <= COL_W'(dim_last(cfg_data, MAX_WIDTH));
          col     <= '0;
          row     <= '0;
          row_sum <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          h_last  <= ROW_IDX_W'(dim_last(cfg_data, MAX_HEIGHT));
          col     <= '0;
          row     <= '0;
          row_sum <= '0;
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      if (row_end) begin
        col     <= '0;
        row_sum <= '0;
        row     <= (row == h_last) ? '0 : row + ROW_IDX_W'(1);
      end else begin
        col     <= col + COL_W'(1);
        row_sum <= row_sum_new;
      end
    end
  end

endmodule

### hdl/integral_image_stream.sv
// ---------------------------------------------------------------------------
// Integral image stream
// Summed-area value for every pixel of a raster-order frame.
// ---------------------------------------------------------------------------
//  channel   dir   handshake                    content
//  s_axis    in    s_axis_tvalid/s_axis_tready  pixel
//  m_axis    out   m_axis_tvalid/m_axis_tready  area_sum, frame_end on tlast
//  cfg       in    cfg_valid/cfg_ready          register index and data
//
//  One pixel per cycle sustained while the sink keeps up; results pass the
//  adder stage and the output register. The rate is set by the single
//  line-store read and write per pixel, a same-column write forwarded to the read.
//  Synchronous reset clears position, row sum and handshake state; the line
//  store needs no clearing since row 0 writes every entry before it is read.
//  A stalled output holds the adder stage, which holds the input.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module integral_image_stream
  import iis_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [PIXEL_W-1:0]     s_axis_tdata,   // [7:0] pixel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [27:0] area_sum, [31:28] zero
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]       cfg_data
);

  localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_IDX_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int USE_BITS  = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
  localparam int ROW_RAW_W = COL_W + USE_BITS;
  localparam int ROW_W     = (ROW_RAW_W < SUM_W) ? ROW_RAW_W : SUM_W;

  logic              in_acc;
  logic [COL_W-1:0]  scan_col;
  logic [ROW_W-1:0]  scan_sum;
  scan_flags_t       scan_flags;

  logic              s1_valid;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row_sum;
  scan_flags_t       s1_flags;
  logic              s1_fwd;
  logic [SUM_W-1:0]  s1_fwd_data;
  logic              s1_adv;
  logic [SUM_W-1:0]  rd_data;
  logic [SUM_W-1:0]  above;
  logic [SUM_W-1:0]  area_sum;

  logic              out_valid;
  logic [SUM_W-1:0]  out_sum;
  logic              out_end;

  assign cfg_ready     = 1'b1;
  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  iis_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COL_W     (COL_W),
    .ROW_IDX_W (ROW_IDX_W),
    .USE_BITS  (USE_BITS),
    .ROW_W     (ROW_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (in_acc),
    .pixel      (s_axis_tdata),
    .col        (scan_col),
    .row_sum_new(scan_sum),
    .flags      (scan_flags)
  );

  iis_line_store #(
    .DEPTH (MAX_WIDTH),
    .ADDR_W(COL_W),
    .DATA_W(SUM_W)
  ) u_line (
    .clk    (clk),
    .rd_en  (in_acc),
    .rd_addr(scan_col),
    .rd_data(rd_data),
    .wr_en  (s1_adv),
    .wr_addr(s1_col),
    .wr_data(area_sum)
  );

  // Add the value above; take a same-column write that raced the read
  assign above    = s1_flags.first_row ? '0 : (s1_fwd ? s1_fwd_data : rd_data);
  assign area_sum = SUM_W'(s1_row_sum) + above;

  // Load the adder stage and capture forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col      <= scan_col;
      s1_row_sum  <= scan_sum;
      s1_flags    <= scan_flags;
      s1_fwd      <= s1_adv && (s1_col == scan_col);
      s1_fwd_data <= area_sum;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sum <= area_sum;
      out_end <= s1_flags.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-SUM_W){1'b0}}, out_sum};
  assign m_axis_tlast  = out_end;

  `ASSERT_AT(a_full_blocks_input, s1_valid && !s1_adv, !s_axis_tready)
  `ASSERT_NEXT(a_accept_fills_stage, in_acc, s1_valid)
  `ASSERT_NEXT(a_frame_wraps, in_acc && scan_flags.frame_end, scan_flags.first_row)

endmodule

### sim/integral_image_stream_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Integral image stream testbench
// Streams raster-order pixels through the block under several frame sizes
// and flow-control patterns. A local summed-area predictor tracks position,
// row sum and the line of previous-row sums. Every result is checked against
// it in order, covering the value, the zero padding and the frame-end flag.
// ---------------------------------------------------------------------------
module integral_image_stream_tb;
  import iis_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  // Indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    logic [SUM_W-1:0] area_sum;
    logic             frame_end;
  } area_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIXEL_W-1:0]     s_axis_tdata = '0;      // [7:0] pixel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;           // [27:0] area_sum, [31:28] zero
  logic                   m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DIM_W-1:0]       cfg_data = '0;

  // Stimulus and scoreboard
  logic [PIXEL_W-1:0] pixels_pending[$];
  area_result_t       area_sums_due[$];
  area_result_t       want;
  int                 pixels_queued = 0;
  int                 results_seen = 0;
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 send_idle_pct = 0;
  int                 sink_stall_pct = 0;
  int                 hold_left = 0;
  logic               hold_req = 1'b0;

  // Predictor state
  logic [DIM_W-1:0] width_cfg;
  logic [DIM_W-1:0] height_cfg;
  logic [SUM_W-1:0] row_sum;
  logic [SUM_W-1:0] line_sums[MAX_WIDTH];
  int               scan_col;
  int               scan_row;

  integral_image_stream #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_W)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Zero counts as one, oversize saturates
  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void restart_frame();
    row_sum  = '0;
    scan_col = 0;
    scan_row = 0;
  endfunction

  function automatic void apply_dim_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [DIM_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_cfg = data;
        restart_frame();
      end
      REG_IMAGE_HEIGHT: begin
        height_cfg = data;
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  // Advance the scan by one pixel and return its summed-area value
  function automatic area_result_t predict_area_sum(input logic [PIXEL_W-1:0] pixel);
    int               w;
    int               h;
    int               c;
    logic [SUM_W-1:0] above;
    area_result_t     r;
    w = clamp_dim(width_cfg, MAX_WIDTH);
    h = clamp_dim(height_cfg, MAX_HEIGHT);
    if (scan_col >= w) scan_col = 0;
    if (scan_row >= h) scan_row = 0;
    c = scan_col;
    row_sum = row_sum + SUM_W'(pixel);
    above = (scan_row == 0) ? '0 : line_sums[c];
    r.area_sum = row_sum + above;
    line_sums[c] = r.area_sum;
    r.frame_end = (scan_row == h - 1) && (c == w - 1);
    scan_col = c + 1;
    if (scan_col >= w) begin
      scan_col = 0;
      row_sum  = '0;
      scan_row = scan_row + 1;
      if (scan_row >= h) scan_row = 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, exp_val);
    error_count++;
  endtask

  // Pixel driver: hold the item until taken, then offer the next or idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pixels_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= pixels_pending.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Result receiver
  always @(posedge clk) begin
    m_axis_tready <= !rst && hold_left == 0 && $urandom_range(99) >= sink_stall_pct;
  end

  // Monitor: track register writes, predict on accepted pixels, check results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_dim_write(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) area_sums_due.push_back(predict_area_sum(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (area_sums_due.size() == 0) begin
          report_mismatch("result with nothing pending", m_axis_tdata, 0);
        end else begin
          want = area_sums_due.pop_front();
          if (m_axis_tdata[SUM_W-1:0] !== want.area_sum)
            report_mismatch("area_sum", 32'(m_axis_tdata[SUM_W-1:0]), 32'(want.area_sum));
          if (m_axis_tdata[OUT_TDATA_W-1:SUM_W] !== '0)
            report_mismatch("tdata padding", 32'(m_axis_tdata[OUT_TDATA_W-1:SUM_W]), 0);
          if (m_axis_tlast !== want.frame_end)
            report_mismatch("frame_end", 32'(m_axis_tlast), 32'(want.frame_end));
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integral_image_stream_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // Queue updates happen on the falling edge, away from the driver
  task automatic queue_pixel(input logic [PIXEL_W-1:0] p);
    @(negedge clk);
    pixels_pending.push_back(p);
    pixels_queued++;
  endtask

  task automatic queue_random(input int n);
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      pixels_pending.push_back(PIXEL_W'($urandom_range(255)));
      pixels_queued++;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_seen != pixels_queued);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(input int send_pct, input int stall_pct);
    @(posedge clk);
    send_idle_pct  <= send_pct;
    sink_stall_pct <= stall_pct;
  endtask

  initial begin
    width_cfg  = DIM_RESET;
    height_cfg = DIM_RESET;
    foreach (line_sums[i]) line_sums[i] = '0;
    restart_frame();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: default frame size, pixel extremes
    queue_pixel(8'd0);
    queue_pixel(8'd255);
    queue_pixel(8'd255);
    wait_drained();

    // 2x2 frame, then wrap into the next frame
    set_frame(DIM_W'(2), DIM_W'(2));
    repeat (6) queue_pixel(8'd255);
    wait_drained();

    // Zero sizes count as one
    set_frame(DIM_W'(0), DIM_W'(0));
    queue_pixel(8'd255);
    queue_pixel(8'd1);
    queue_pixel(8'd128);
    wait_drained();

    // Writes to unmapped indexes change nothing
    write_reg(REG_SPARE_A, DIM_W'(2047));
    write_reg(REG_SPARE_B, DIM_W'(0));
    queue_pixel(8'd77);
    wait_drained();

    // A register write in mid-frame restarts the frame
    set_frame(DIM_W'(3), DIM_W'(3));
    repeat (4) queue_pixel(8'd255);
    wait_drained();
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(3));
    for (int i = 0; i < 9; i++) queue_pixel(PIXEL_W'(i * 31));
    wait_drained();

    // Random frames under each flow-control pattern
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: set_idle(0, 0);
        1: set_idle(77, 0);
        2: set_idle(0, 77);
        default: set_idle(13, 13);
      endcase
      for (int k = 0; k < 3; k++) begin
        if (k == 0) begin
          set_frame(DIM_W'($urandom_range(2047)), DIM_W'($urandom_range(2047)));
          queue_random(30);
        end else begin
          set_frame(DIM_W'($urandom_range(12, 1)), DIM_W'($urandom_range(8, 1)));
          queue_random(70);
        end
        // Stall the output long enough to back up the input
        if (mode == 0 && k == 1) begin
          queue_random(40);
          @(posedge clk);
          hold_req <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
        end
        wait_drained();
      end
    end

    if (area_sums_due.size() != 0)
      report_mismatch("results never arrived", 0, area_sums_due.size());
    if (error_count == 0) begin
      $display("integral_image_stream_tb OK");
    end else begin
      $display("integral_image_stream_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/iis_pkg.sv
hdl/iis_line_store.sv
hdl/iis_scan.sv
hdl/integral_image_stream.sv
sim/integral_image_stream_tb.sv
